// ===== rtl/core/bts_pkg.sv =====
// ----------------------------------------------------------------------------
// bts_pkg
// Shared types and constants for the bilinear texture sampler.
// ----------------------------------------------------------------------------
package bts_pkg;

  localparam int DEF_MAX_WIDTH  = 256;
  localparam int DEF_MAX_HEIGHT = 256;

  localparam int TEXEL_W = 24;
  localparam int DIM_W   = 9;
  localparam int CHAN_W  = 16;

  // Configuration register indexes
  localparam logic REG_TEX_WIDTH  = 1'b0;
  localparam logic REG_TEX_HEIGHT = 1'b1;

  // Item kinds
  localparam logic ACT_WRITE  = 1'b0;
  localparam logic ACT_SAMPLE = 1'b1;

  // Magenta, returned when the texture width or height is zero
  localparam logic [CHAN_W-1:0] MAGENTA_HI = 16'hFF00;
  localparam logic [CHAN_W-1:0] MAGENTA_LO = 16'h0000;

  // Control that travels with each beat down the pipe
  typedef struct packed {
    logic vld;
    logic smp;
    logic nt;
  } bts_ctl_t;

endpackage

// ===== rtl/core/bilinear_texture_sampler_unit.sv =====
// ----------------------------------------------------------------------------
// bilinear_texture_sampler_unit
// RGB888 texture store with a bilinear sampler, u wrapped and v clamped.
// ----------------------------------------------------------------------------
// Takes one beat per cycle, writes and samples alike, and returns a sample's
// filtered color from the last stage. The pipe has five stages:
// coordinate scale, address forming, texel fetch, horizontal and vertical
// blend. The fetch stage holds four copies of the texel memory, each written
// by every texel write, so the four neighbours are read in the same cycle. Writes
// pass through the pipe to the fetch stage and produce no result. The whole
// pipe holds while a result waits under stall.
module bilinear_texture_sampler_unit
  import bts_pkg::*;
#(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [DIM_W-1:0]  cfg_data,
  input  logic              item_valid,
  output logic              item_stall,
  input  logic              action,
  input  logic [15:0]       texel_index,
  input  logic [23:0]       texel_rgb,
  input  logic [31:0]       u_coord,
  input  logic [31:0]       v_coord,
  output logic              result_valid,
  input  logic              result_stall,
  output logic [CHAN_W-1:0] red_out,
  output logic [CHAN_W-1:0] green_out,
  output logic [CHAN_W-1:0] blue_out,
  output logic              no_texture
);

  localparam int STORE = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = $clog2(STORE);

  logic [DIM_W-1:0]   tex_width, tex_height;
  logic               adv;
  bts_ctl_t           ctl2, ctl3, ctl5;
  logic               we2;
  logic [AW-1:0]      waddr2, a00, a10, a01, a11;
  logic [23:0]        wdata2;
  logic [15:0]        tx2, ty2, tx3, ty3;
  logic [TEXEL_W-1:0] t00, t10, t01, t11;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      tex_width  <= '0;
      tex_height <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_TEX_WIDTH:  tex_width  <= cfg_data;
        REG_TEX_HEIGHT: tex_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // Advance the whole pipe unless the last stage holds an untaken result beat
  assign result_valid = ctl5.vld && ctl5.smp;
  assign adv          = !(result_valid && result_stall);
  assign item_stall   = !adv;

  bts_coord #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT),
    .AW        (AW)
  ) u_coord_stg (
    .clk        (clk),
    .rst        (rst),
    .adv        (adv),
    .in_vld     (item_valid),
    .action     (action),
    .texel_index(texel_index),
    .texel_rgb  (texel_rgb),
    .u_coord    (u_coord),
    .v_coord    (v_coord),
    .tex_width  (tex_width),
    .tex_height (tex_height),
    .ctl2       (ctl2),
    .we2        (we2),
    .waddr2     (waddr2),
    .wdata2     (wdata2),
    .a00        (a00),
    .a10        (a10),
    .a01        (a01),
    .a11        (a11),
    .tx2        (tx2),
    .ty2        (ty2)
  );

  // Fetch stage: four memory copies
  bts_ram #(.DEPTH(STORE), .AW(AW)) u_ram00 (
    .clk(clk), .en(adv), .we(we2), .waddr(waddr2), .wdata(wdata2),
    .raddr(a00), .rdata(t00)
  );
  bts_ram #(.DEPTH(STORE), .AW(AW)) u_ram10 (
    .clk(clk), .en(adv), .we(we2), .waddr(waddr2), .wdata(wdata2),
    .raddr(a10), .rdata(t10)
  );
  bts_ram #(.DEPTH(STORE), .AW(AW)) u_ram01 (
    .clk(clk), .en(adv), .we(we2), .waddr(waddr2), .wdata(wdata2),
    .raddr(a01), .rdata(t01)
  );
  bts_ram #(.DEPTH(STORE), .AW(AW)) u_ram11 (
    .clk(clk), .en(adv), .we(we2), .waddr(waddr2), .wdata(wdata2),
    .raddr(a11), .rdata(t11)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl3 <= '0;
    end else if (adv) begin
      ctl3 <= ctl2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      tx3 <= tx2;
      ty3 <= ty2;
    end
  end

  bts_blend u_blend (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .ctl3      (ctl3),
    .t00       (t00),
    .t10       (t10),
    .t01       (t01),
    .t11       (t11),
    .tx3       (tx3),
    .ty3       (ty3),
    .ctl5      (ctl5),
    .red_out   (red_out),
    .green_out (green_out),
    .blue_out  (blue_out),
    .no_texture(no_texture)
  );

  // Checks
  a_magenta: assert property (@(posedge clk) disable iff (rst)
    result_valid && no_texture |->
      red_out == MAGENTA_HI && green_out == MAGENTA_LO && blue_out == MAGENTA_HI)
    else $error("no-texture result is not magenta");

  a_stall_src: assert property (@(posedge clk) disable iff (rst)
    item_stall |-> result_valid && result_stall)
    else $error("input stalled without a held output beat");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    !adv |=> $stable(ctl3) && $stable(tx3) && $stable(ty3))
    else $error("fetch stage moved during a hold");

endmodule

// ===== rtl/core/bts_ram.sv =====
// ----------------------------------------------------------------------------
// bts_ram
// Texel memory copy: one write port, one registered read port.
// ----------------------------------------------------------------------------
module bts_ram
  import bts_pkg::*;
#(
  parameter int DEPTH = DEF_MAX_WIDTH * DEF_MAX_HEIGHT,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic               clk,
  input  logic               en,
  input  logic               we,
  input  logic [AW-1:0]      waddr,
  input  logic [TEXEL_W-1:0] wdata,
  input  logic [AW-1:0]      raddr,
  output logic [TEXEL_W-1:0] rdata
);

  logic [TEXEL_W-1:0] mem [DEPTH];

  // Write and read in the same stage, read data registered
  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/core/bts_coord.sv =====
// ----------------------------------------------------------------------------
// bts_coord
// Coordinate stages: wrap u, clamp v, scale, then form the four neighbour
// addresses and the fractional weights.
// ----------------------------------------------------------------------------
module bts_coord
  import bts_pkg::*;
#(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
  parameter int AW         = $clog2(MAX_WIDTH * MAX_HEIGHT)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             adv,
  input  logic             in_vld,
  input  logic             action,
  input  logic [15:0]      texel_index,
  input  logic [23:0]      texel_rgb,
  input  logic [31:0]      u_coord,
  input  logic [31:0]      v_coord,
  input  logic [DIM_W-1:0] tex_width,
  input  logic [DIM_W-1:0] tex_height,
  output bts_ctl_t         ctl2,
  output logic             we2,
  output logic [AW-1:0]    waddr2,
  output logic [23:0]      wdata2,
  output logic [AW-1:0]    a00,
  output logic [AW-1:0]    a10,
  output logic [AW-1:0]    a01,
  output logic [AW-1:0]    a11,
  output logic [15:0]      tx2,
  output logic [15:0]      ty2
);

  localparam int STORE = MAX_WIDTH * MAX_HEIGHT;
  localparam logic [DIM_W-1:0] MAXW = (MAX_WIDTH > 511) ? DIM_W'(511) : DIM_W'(MAX_WIDTH);
  localparam logic [DIM_W-1:0] MAXH = (MAX_HEIGHT > 511) ? DIM_W'(511) : DIM_W'(MAX_HEIGHT);

  logic [DIM_W-1:0] w_sat, h_sat;
  logic [16:0]      fv;
  logic             wr_ok;

  bts_ctl_t         ctl1;
  logic [DIM_W-1:0] w1, h1;
  logic [24:0]      x1p;
  logic [25:0]      y1p;
  logic             we1;
  logic [AW-1:0]    waddr1;
  logic [23:0]      wdata1;

  logic [DIM_W-1:0] wm1, hm1, x0, y0, xn, yn;
  logic [9:0]       y0w, x0i, y0i;
  logic [18:0]      row0, row1;

  // Saturate dimensions, clamp v
  always_comb begin
    w_sat = (tex_width > MAXW) ? MAXW : tex_width;
    h_sat = (tex_height > MAXH) ? MAXH : tex_height;
    if (v_coord[31]) begin
      fv = 17'd0;
    end else if (v_coord > 32'h0001_0000) begin
      fv = 17'h1_0000;
    end else begin
      fv = v_coord[16:0];
    end
    wr_ok = ({16'd0, texel_index} < 32'(STORE));
  end

  // Stage 1: scale coordinates by dimension minus one
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl1 <= '0;
    end else if (adv) begin
      ctl1.vld <= in_vld;
      ctl1.smp <= (action == ACT_SAMPLE);
      ctl1.nt  <= (w_sat == '0) || (h_sat == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      w1     <= w_sat;
      h1     <= h_sat;
      x1p    <= {9'd0, u_coord[15:0]} * {16'd0, w_sat - DIM_W'(1)};
      y1p    <= {9'd0, fv} * {17'd0, h_sat - DIM_W'(1)};
      we1    <= in_vld && (action == ACT_WRITE) && wr_ok;
      waddr1 <= AW'(texel_index);
      wdata1 <= texel_rgb;
    end
  end

  // Neighbours, clamped to the last column and row
  always_comb begin
    wm1 = w1 - DIM_W'(1);
    hm1 = h1 - DIM_W'(1);
    x0i = {1'b0, x1p[24:16]};
    y0i = y1p[25:16];
    x0  = (x0i > {1'b0, wm1}) ? wm1 : x0i[DIM_W-1:0];
    y0  = (y0i > {1'b0, hm1}) ? hm1 : y0i[DIM_W-1:0];
    xn  = ({1'b0, x0} + 10'd1 < {1'b0, w1}) ? x0 + DIM_W'(1) : wm1;
    yn  = ({1'b0, y0} + 10'd1 < {1'b0, h1}) ? y0 + DIM_W'(1) : hm1;
    y0w = {1'b0, y0};
    row0 = {9'd0, y0w} * {10'd0, w1};
    row1 = {10'd0, yn} * {10'd0, w1};
  end

  // Stage 2: linear addresses and weights
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl2 <= '0;
    end else if (adv) begin
      ctl2 <= ctl1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      we2    <= we1 && ctl1.vld;
      waddr2 <= waddr1;
      wdata2 <= wdata1;
      a00    <= AW'(row0 + 19'(x0));
      a10    <= AW'(row0 + 19'(xn));
      a01    <= AW'(row1 + 19'(x0));
      a11    <= AW'(row1 + 19'(xn));
      tx2    <= x1p[15:0];
      ty2    <= y1p[15:0];
    end
  end

endmodule

// ===== rtl/core/bts_blend.sv =====
// ----------------------------------------------------------------------------
// bts_blend
// Blend stages: mix along x per channel, then along y, truncate to Q8.8.
// ----------------------------------------------------------------------------
module bts_blend
  import bts_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               adv,
  input  bts_ctl_t           ctl3,
  input  logic [TEXEL_W-1:0] t00,
  input  logic [TEXEL_W-1:0] t10,
  input  logic [TEXEL_W-1:0] t01,
  input  logic [TEXEL_W-1:0] t11,
  input  logic [15:0]        tx3,
  input  logic [15:0]        ty3,
  output bts_ctl_t           ctl5,
  output logic [CHAN_W-1:0]  red_out,
  output logic [CHAN_W-1:0]  green_out,
  output logic [CHAN_W-1:0]  blue_out,
  output logic               no_texture
);

  bts_ctl_t    ctl4;
  logic [15:0] ty4;
  logic [16:0] txc, tyc;
  logic [23:0] r0 [3];
  logic [23:0] r1 [3];
  logic [23:0] r0n [3];
  logic [23:0] r1n [3];
  logic [40:0] mix [3];

  // Horizontal blend of the top and bottom rows
  always_comb begin
    txc = 17'h1_0000 - {1'b0, tx3};
    for (int k = 0; k < 3; k++) begin
      r0n[k] = {16'd0, t00[8*k +: 8]} * {7'd0, txc} + {16'd0, t10[8*k +: 8]} * {8'd0, tx3};
      r1n[k] = {16'd0, t01[8*k +: 8]} * {7'd0, txc} + {16'd0, t11[8*k +: 8]} * {8'd0, tx3};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl4 <= '0;
    end else if (adv) begin
      ctl4 <= ctl3;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      r0  <= r0n;
      r1  <= r1n;
      ty4 <= ty3;
    end
  end

  // Vertical blend
  always_comb begin
    tyc = 17'h1_0000 - {1'b0, ty4};
    for (int k = 0; k < 3; k++) begin
      mix[k] = {17'd0, r0[k]} * {24'd0, tyc} + {17'd0, r1[k]} * {25'd0, ty4};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl5 <= '0;
    end else if (adv) begin
      ctl5 <= ctl4;
    end
  end

  // Output register, magenta when no texture
  always_ff @(posedge clk) begin
    if (adv) begin
      no_texture <= ctl4.nt;
      if (ctl4.nt) begin
        red_out   <= MAGENTA_HI;
        green_out <= MAGENTA_LO;
        blue_out  <= MAGENTA_HI;
      end else begin
        red_out   <= mix[2][39:24];
        green_out <= mix[1][39:24];
        blue_out  <= mix[0][39:24];
      end
    end
  end

endmodule

// ===== bench/bts_checker.sv =====
// ----------------------------------------------------------------------------
// bts_checker
// Predicts and checks sampler results from the beats seen on the channels.
// ----------------------------------------------------------------------------
// Keeps its own copy of the texel store and the two size registers. Every
// sample beat taken on the input side queues one predicted color. Every
// result beat is compared with the oldest prediction, field by field.
module bts_checker
  import bts_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [DIM_W-1:0]  cfg_data,
  input  logic              item_valid,
  input  logic              item_stall,
  input  logic              action,
  input  logic [15:0]       texel_index,
  input  logic [23:0]       texel_rgb,
  input  logic [31:0]       u_coord,
  input  logic [31:0]       v_coord,
  input  logic              result_valid,
  input  logic              result_stall,
  input  logic [CHAN_W-1:0] red_out,
  input  logic [CHAN_W-1:0] green_out,
  input  logic [CHAN_W-1:0] blue_out,
  input  logic              no_texture,
  output int                fail_count,
  output int                colors_pending,
  output int                colors_checked,
  output int                texels_written
);

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
    logic              nt;
  } color_t;

  logic [TEXEL_W-1:0] texels [0:65535];
  logic [DIM_W-1:0]   width_reg;
  logic [DIM_W-1:0]   height_reg;
  color_t             color_queue [$];

  assign colors_pending = color_queue.size();

  // Blend one channel: along x first, then along y, keep Q8.8
  function automatic logic [15:0] blend(input logic [7:0] c00, input logic [7:0] c10,
                                        input logic [7:0] c01, input logic [7:0] c11,
                                        input logic [31:0] tx, input logic [31:0] ty);
    logic [63:0] row0;
    logic [63:0] row1;
    logic [63:0] mix;
    row0 = 64'(c00) * (64'd65536 - tx) + 64'(c10) * tx;
    row1 = 64'(c01) * (64'd65536 - tx) + 64'(c11) * tx;
    mix  = row0 * (64'd65536 - ty) + row1 * ty;
    return mix[39:24];
  endfunction

  function automatic color_t filter_texels(input logic [31:0] u, input logic [31:0] v);
    color_t      c;
    logic [31:0] w, h, fu, fv, x, y, x0, y0, x1, y1, tx, ty;
    logic [23:0] t00, t10, t01, t11;
    w = (width_reg > 256) ? 32'd256 : 32'(width_reg);
    h = (height_reg > 256) ? 32'd256 : 32'(height_reg);
    if (w == 0 || h == 0) begin
      c.red = MAGENTA_HI;
      c.green = MAGENTA_LO;
      c.blue = MAGENTA_HI;
      c.nt = 1'b1;
      return c;
    end
    // wrap u, clamp v to [0, 1]
    fu = {16'd0, u[15:0]};
    if (v[31]) fv = 0;
    else if (v > 32'd65536) fv = 32'd65536;
    else fv = v;
    x = fu * (w - 1);
    y = fv * (h - 1);
    x0 = x >> 16;
    y0 = y >> 16;
    tx = {16'd0, x[15:0]};
    ty = {16'd0, y[15:0]};
    x1 = (x0 + 1 < w) ? x0 + 1 : w - 1;
    y1 = (y0 + 1 < h) ? y0 + 1 : h - 1;
    if (x0 > w - 1) x0 = w - 1;
    if (y0 > h - 1) y0 = h - 1;
    t00 = texels[16'(y0 * w + x0)];
    t10 = texels[16'(y0 * w + x1)];
    t01 = texels[16'(y1 * w + x0)];
    t11 = texels[16'(y1 * w + x1)];
    c.red   = blend(t00[23:16], t10[23:16], t01[23:16], t11[23:16], tx, ty);
    c.green = blend(t00[15:8], t10[15:8], t01[15:8], t11[15:8], tx, ty);
    c.blue  = blend(t00[7:0], t10[7:0], t01[7:0], t11[7:0], tx, ty);
    c.nt = 1'b0;
    return c;
  endfunction

  initial begin
    fail_count = 0;
    colors_checked = 0;
    texels_written = 0;
    width_reg = '0;
    height_reg = '0;
  end

  always @(posedge clk) begin
    color_t want;
    if (rst) begin
      width_reg = '0;
      height_reg = '0;
    end else begin
      // track register writes
      if (cfg_we) begin
        if (cfg_index == REG_TEX_WIDTH) width_reg = cfg_data;
        else height_reg = cfg_data;
      end
      // compare a result beat with the oldest prediction
      if (result_valid && !result_stall) begin
        if (color_queue.size() == 0) begin
          $error("result beat with no color expected");
          fail_count++;
        end else begin
          want = color_queue.pop_front();
          colors_checked++;
          if (red_out !== want.red) begin
            $error("red_out expected %0d got %0d", want.red, red_out);
            fail_count++;
          end
          if (green_out !== want.green) begin
            $error("green_out expected %0d got %0d", want.green, green_out);
            fail_count++;
          end
          if (blue_out !== want.blue) begin
            $error("blue_out expected %0d got %0d", want.blue, blue_out);
            fail_count++;
          end
          if (no_texture !== want.nt) begin
            $error("no_texture expected %0d got %0d", want.nt, no_texture);
            fail_count++;
          end
        end
      end
      // predict on each input beat
      if (item_valid && !item_stall) begin
        if (action == ACT_SAMPLE) begin
          color_queue.push_back(filter_texels(u_coord, v_coord));
        end else begin
          texels[texel_index] = texel_rgb;
          texels_written++;
        end
      end
    end
  end

endmodule

// ===== bench/bilinear_texture_sampler_unit_tb.sv =====
// ----------------------------------------------------------------------------
// bilinear_texture_sampler_unit_tb
// Stimulus and verdict for the bilinear texture sampler.
// ----------------------------------------------------------------------------
// Loads textures of many sizes, zero and oversized ones among them, then
// samples them at directed and random coordinates under varying idle and
// stall pressure. Checking is done by bts_checker.
module bilinear_texture_sampler_unit_tb;
  import bts_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;

  logic              clk;
  logic              rst;
  logic              cfg_we;
  logic              cfg_index;
  logic [DIM_W-1:0]  cfg_data;
  logic              item_valid;
  logic              item_stall;
  logic              action;
  logic [15:0]       texel_index;
  logic [23:0]       texel_rgb;
  logic [31:0]       u_coord;
  logic [31:0]       v_coord;
  logic              result_valid;
  logic              result_stall;
  logic [CHAN_W-1:0] red_out;
  logic [CHAN_W-1:0] green_out;
  logic [CHAN_W-1:0] blue_out;
  logic              no_texture;

  int fail_count;
  int colors_pending;
  int colors_checked;
  int texels_written;
  int idle_pct;
  int stall_pct;
  int quiet_cycles;

  bilinear_texture_sampler_unit DUT (.*);

  bts_checker checker_i (.*);

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  // receiver stall, redrawn each falling edge
  always @(negedge clk) begin
    result_stall = ($urandom_range(0, 99) < stall_pct);
  end

  // watchdog on cycles with no beat taken anywhere
  always @(posedge clk) begin
    if (rst || cfg_we || (item_valid && !item_stall) || (result_valid && !result_stall))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic send_beat(input logic act, input logic [15:0] idx, input logic [23:0] rgb,
                           input logic [31:0] u, input logic [31:0] v);
    while ($urandom_range(0, 99) < idle_pct) begin
      item_valid = 1'b0;
      @(negedge clk);
    end
    item_valid = 1'b1;
    action = act;
    texel_index = idx;
    texel_rgb = rgb;
    u_coord = u;
    v_coord = v;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    @(negedge clk);
    item_valid = 1'b0;
  endtask

  // set both sizes once the pipe has drained
  task automatic set_size(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h);
    while (colors_pending != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = REG_TEX_WIDTH;
    cfg_data = w;
    @(negedge clk);
    cfg_index = REG_TEX_HEIGHT;
    cfg_data = h;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // write every texel the sampler can reach
  task automatic fill_texture(input int w, input int h);
    int ew;
    int eh;
    ew = (w > 256) ? 256 : w;
    eh = (h > 256) ? 256 : h;
    for (int i = 0; i < ew * eh; i++)
      send_beat(ACT_WRITE, 16'(i), 24'($urandom), $urandom, $urandom);
  endtask

  function automatic logic [31:0] pick_v();
    case ($urandom_range(0, 7))
      0: return $urandom;
      1: return 32'h0001_0000;
      2: return 32'h8000_0000 | $urandom;
      default: return 32'($urandom_range(0, 65536));
    endcase
  endfunction

  initial begin
    int dims [12][2] = '{'{1, 1}, '{2, 2}, '{5, 7}, '{511, 1}, '{1, 511}, '{0, 5},
                         '{9, 9}, '{7, 0}, '{3, 4}, '{256, 1}, '{2, 3}, '{1, 256}};
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = REG_TEX_WIDTH;
    cfg_data = '0;
    item_valid = 1'b0;
    action = ACT_WRITE;
    texel_index = '0;
    texel_rgb = '0;
    u_coord = '0;
    v_coord = '0;
    result_stall = 1'b0;
    idle_pct = 0;
    stall_pct = 0;
    quiet_cycles = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // no texture: magenta
    set_size(DIM_W'(0), DIM_W'(0));
    send_beat(ACT_SAMPLE, '0, '0, 32'h0000_8000, 32'h0000_8000);
    send_beat(ACT_SAMPLE, '0, '0, 32'hFFFF_FFFF, 32'h8000_0000);

    // small texture with extreme colors, then the coordinate corners
    set_size(DIM_W'(4), DIM_W'(3));
    for (int i = 0; i < 12; i++)
      send_beat(ACT_WRITE, 16'(i), (i % 2) ? 24'hFFFFFF : 24'h000000, '0, '0);
    send_beat(ACT_WRITE, 16'hFFFF, 24'hFFFFFF, '0, '0);
    send_beat(ACT_SAMPLE, '0, '0, 32'h0000_0000, 32'h0000_0000);
    send_beat(ACT_SAMPLE, '0, '0, 32'h0000_FFFF, 32'h0001_0000);
    send_beat(ACT_SAMPLE, '0, '0, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
    send_beat(ACT_SAMPLE, '0, '0, 32'h8000_0000, 32'h8000_0000);
    send_beat(ACT_SAMPLE, '0, '0, 32'h0000_8000, 32'h0000_8000);
    send_beat(ACT_SAMPLE, '0, '0, 32'h7FFF_4000, 32'hFFFF_FFFF);

    // random phases across sizes and pressure
    for (int p = 0; p < 12; p++) begin
      case (p % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 61; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 61; end
        default: begin idle_pct = 29; stall_pct = 29; end
      endcase
      set_size(DIM_W'(dims[p][0]), DIM_W'(dims[p][1]));
      fill_texture(dims[p][0], dims[p][1]);
      for (int n = 0; n < 14; n++) begin
        if ($urandom_range(0, 3) == 0)
          send_beat(ACT_WRITE, 16'($urandom), 24'($urandom), $urandom, $urandom);
        else
          send_beat(ACT_SAMPLE, 16'($urandom), 24'($urandom), $urandom, pick_v());
      end
    end

    // drain, then allow the pipe to settle
    idle_pct = 0;
    stall_pct = 0;
    while (colors_pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    $display("checked %0d filtered colors over %0d texel writes", colors_checked,
             texels_written);
    $display("sizes from empty to 256 wide and tall, oversized registers included");
    if (fail_count == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
